/* hdl/mmn_pkg.sv */
// Shared types and constants for the min-max voxel normalizer.
`timescale 1ns / 1ps

package mmn_pkg;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_CONVERT = 2'd2
  } cmd_e;

  localparam int unsigned SampleW     = 16;
  localparam int unsigned PixelW      = 8;
  localparam int unsigned NumScale    = 510;
  // Numerator d*510 + r is below 2^25, as is the divisor 2r shifted by eight.
  localparam int unsigned NumW        = 25;
  localparam int unsigned DenW        = SampleW + 1;
  localparam int unsigned DivSteps    = PixelW;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [SampleW-1:0] MinReset  = '1;
  localparam logic [SampleW-1:0] MaxReset  = '0;
  localparam logic [PixelW-1:0]  FullScale = '1;

  // One pending convert, fully classified by the front end.
  typedef struct packed {
    logic                pass;     // one-byte mode, lo_byte goes out as is
    logic                zero;     // sample below the running minimum
    logic [PixelW-1:0]   lo_byte;
    logic [SampleW-1:0]  diff;     // sample minus minimum
    logic [SampleW-1:0]  range;    // max - min, or 1 if max <= min
  } job_t;

endpackage

/* hdl/mmn_front.sv */
// Front end: command decode, running extremes and job classification.
`timescale 1ns / 1ps

module mmn_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  input  logic                          accept_i,
  input  logic [1:0]                    command_i,
  input  logic [mmn_pkg::PixelW-1:0]    sample_low_i,
  input  logic [mmn_pkg::PixelW-1:0]    sample_high_i,
  output logic                          push_o,
  output mmn_pkg::job_t                 job_o
);

  logic                          mode_q;
  logic [mmn_pkg::SampleW-1:0]   min_q, min_d;
  logic [mmn_pkg::SampleW-1:0]   max_q, max_d;
  logic [mmn_pkg::SampleW-1:0]   sample;
  logic                          push;

  assign sample = {sample_high_i, sample_low_i};

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    push  = 1'b0;
    if (accept_i) begin
      case (mmn_pkg::cmd_e'(command_i))
        mmn_pkg::CMD_START: begin
          min_d = mmn_pkg::MinReset;
          max_d = mmn_pkg::MaxReset;
        end
        mmn_pkg::CMD_SCAN: begin
          if (mode_q) begin
            if (sample < min_q) min_d = sample;
            if (sample > max_q) max_d = sample;
          end
        end
        mmn_pkg::CMD_CONVERT: begin
          push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    job_o.pass    = ~mode_q;
    job_o.zero    = sample < min_q;
    job_o.lo_byte = sample_low_i;
    job_o.diff    = sample - min_q;
    job_o.range   = (max_q > min_q) ? (max_q - min_q) : mmn_pkg::SampleW'(1);
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      min_q  <= mmn_pkg::MinReset;
      max_q  <= mmn_pkg::MaxReset;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

/* hdl/mmn_queue.sv */
// Small job queue between the front end and the divider.
`timescale 1ns / 1ps

module mmn_queue #(
  parameter int unsigned Depth = mmn_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mmn_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output mmn_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mmn_pkg::job_t        mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* hdl/mmn_back.sv */
// Back end: pass, zero or rounded saturated division of scaled offset by 2r.
`timescale 1ns / 1ps

module mmn_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  mmn_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic [mmn_pkg::PixelW-1:0]  pixel_value_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CHK  = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

  localparam int unsigned NumW = mmn_pkg::NumW;
  localparam int unsigned CntW = $clog2(mmn_pkg::DivSteps);

  state_e                        state_q, state_d;
  logic [mmn_pkg::SampleW-1:0]   diff_q, diff_d;
  logic [mmn_pkg::SampleW-1:0]   range_q, range_d;
  logic [NumW-1:0]               rem_q, rem_d;
  logic [NumW-1:0]               sh_q, sh_d;
  logic [mmn_pkg::DenW-1:0]      den_q, den_d;
  logic [mmn_pkg::PixelW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [mmn_pkg::PixelW-1:0]    pix_q, pix_d;
  logic                          done_q, done_d;
  logic [NumW-1:0]               den_top;
  logic                          fits;
  logic                          pop;

  assign den_top = {den_q, {(NumW - mmn_pkg::DenW){1'b0}}};
  assign fits    = rem_q >= sh_q;

  always_comb begin
    state_d = state_q;
    diff_d  = diff_q;
    range_d = range_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    pix_d   = pix_q;
    done_d  = 1'b0;
    pop     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop = 1'b1;
          if (job_i.pass) begin
            pix_d  = job_i.lo_byte;
            done_d = 1'b1;
          end else if (job_i.zero) begin
            pix_d  = '0;
            done_d = 1'b1;
          end else begin
            diff_d  = job_i.diff;
            range_d = job_i.range;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        rem_d   = NumW'(diff_q) * NumW'(mmn_pkg::NumScale) + NumW'(range_q);
        den_d   = {range_q, 1'b0};
        state_d = S_CHK;
      end
      S_CHK: begin
        if (rem_q >= den_top) begin
          pix_d   = mmn_pkg::FullScale;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          sh_d    = den_top >> 1;
          cnt_d   = CntW'(mmn_pkg::DivSteps - 1);
          quo_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (fits) rem_d = rem_q - sh_q;
        quo_d = {quo_q[mmn_pkg::PixelW-2:0], fits};
        sh_d  = sh_q >> 1;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          pix_d   = {quo_q[mmn_pkg::PixelW-2:0], fits};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign pop_o         = pop;
  assign done_o        = done_q;
  assign pixel_value_o = pix_q;

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    range_q <= range_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    pix_q   <= pix_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

endmodule

/* hdl/minmax_normalize_u16_to_u8.sv */
// Top level of the min-max voxel normalizer, 16-bit samples to 8-bit pixels.
`timescale 1ns / 1ps
// Usage. A command is transferred at a rising edge where start is high and
// busy is low. Command start clears the running minimum and maximum, scan
// (two-byte mode only) folds the 16-bit sample {sample_high_i, sample_low_i}
// into them, and convert queues a normalized pixel; code 3 is ignored. Start
// and scan take effect at the transfer edge, so a following convert already
// sees them. Each convert gives one pixel on pixel_value_o, marked by done_o
// for exactly one cycle; the receiver has no way to stall it, and results
// leave in order. A one-byte pass-through or a sample below the minimum is
// answered from the idle state, a saturated pixel after the multiply step and
// the range check, a divided pixel after one multiply step, one range check
// and eight restoring division steps. The divider takes no new convert until
// it has finished the last one; scans and starts go at one per cycle while
// busy is low. busy rises when the job queue of QueueDepth entries is full.
// cfg_we_i writes cfg_data_i into the two-byte-mode register; write it only
// while the block is idle. Reset (rst_ni low) sets two-byte mode, minimum
// 65535, maximum 0 and empties the queue.

module minmax_normalize_u16_to_u8 #(
  parameter int unsigned QueueDepth = mmn_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command_i,
  input  logic [mmn_pkg::PixelW-1:0]  sample_low_i,
  input  logic [mmn_pkg::PixelW-1:0]  sample_high_i,
  output logic                        done_o,
  output logic [mmn_pkg::PixelW-1:0]  pixel_value_o
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  mmn_pkg::job_t  push_job;
  mmn_pkg::job_t  head_job;

  // The queue only fills with converts, yet busy holds scans and starts too;
  // it clears as soon as the divider takes the head job.
  assign busy   = q_full;
  assign accept = start & ~q_full;

  mmn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .command_i     (command_i),
    .sample_low_i  (sample_low_i),
    .sample_high_i (sample_high_i),
    .push_o        (push),
    .job_o         (push_job)
  );

  mmn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  mmn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (head_job),
    .pop_o         (pop),
    .done_o        (done_o),
    .pixel_value_o (pixel_value_o)
  );

`ifndef SYNTH
  // A convert is never written into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("job pushed into full queue");
  // The divider only takes a job that is actually there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("job popped from empty queue");
  // Every rise of done_o is preceded by a job taken from the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(pop, 1) || $past(pop, 3) || $past(pop, 11))
    else $error("result without a queued convert");
`endif

endmodule
